[src/mbaq_pkg.sv]
package mbaq_pkg;

  // reply frame: addr, func, byte count, 2 sign bytes, 4 magnitude bytes, CRC lo/hi
  localparam logic [3:0]  FRAME_LEN    = 4'd11;
  localparam logic [3:0]  CRC_BYTES    = 4'd9;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [7:0]  REG_ADDR_HI  = 8'h00;
  localparam logic [7:0]  REG_ADDR_LO  = 8'h46;
  localparam logic [7:0]  REG_CNT_HI   = 8'h00;
  localparam logic [7:0]  REG_CNT_LO   = 8'h03;
  localparam logic [7:0]  RESP_BYTES   = 8'h06;
  localparam logic [7:0]  ADDR_RESET   = 8'h01;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RX      = 1'b1;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_HDR = 2'd1,
    STATUS_CRC = 2'd2
  } status_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic signed [31:0] angle_tenths;
    logic [1:0]         status;
  } out_t;

  // queued job between front and back
  typedef struct packed {
    logic        is_req;
    logic [7:0]  addr;
    logic [31:0] angle;
    status_e     status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // fixed request bytes after the address
  function automatic logic [7:0] req_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd1:    b = FUNC_READ;
      3'd2:    b = REG_ADDR_HI;
      3'd3:    b = REG_ADDR_LO;
      3'd4:    b = REG_CNT_HI;
      3'd5:    b = REG_CNT_LO;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[src/mbaq_queue.sv]
module mbaq_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbaq_pkg::cmd_t  push_data_i,
  input  logic            pop_i,
  output mbaq_pkg::cmd_t  pop_data_o,
  output mbaq_pkg::q_stat_t stat_o
);
  import mbaq_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

[src/mbaq_front.sv]
module mbaq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mbaq_pkg::in_t     in_data_i,
  input  mbaq_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output mbaq_pkg::cmd_t    push_data_o
);
  import mbaq_pkg::*;

  logic [7:0]  addr_q;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic        sign_q, sign_d;
  logic [31:0] mag_q, mag_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        accept;
  logic [7:0]  b;
  logic [15:0] rx_crc;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.rx_byte;
  assign rx_crc     = {b, crc_lo_q};

  always_comb begin
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    hdr_bad_d   = hdr_bad_q;
    sign_d      = sign_q;
    mag_d       = mag_q;
    crc_lo_d    = crc_lo_q;
    push_o      = 1'b0;
    push_data_o = '{is_req: 1'b1, addr: addr_q, angle: 32'd0, status: STATUS_OK};

    if (accept) begin
      if (in_data_i.operation == OP_REQUEST) begin
        push_o    = 1'b1;
        cnt_d     = 4'd0;
        crc_d     = CRC_INIT;
        hdr_bad_d = 1'b0;
        sign_d    = 1'b0;
        mag_d     = 32'd0;
        crc_lo_d  = 8'h00;
      end else if (cnt_q < FRAME_LEN) begin
        if (cnt_q < CRC_BYTES) crc_d = crc_feed(crc_q, b);
        cnt_d = cnt_q + 4'd1;
        case (cnt_q)
          4'd0:       if (b != addr_q)     hdr_bad_d = 1'b1;
          4'd1:       if (b != FUNC_READ)  hdr_bad_d = 1'b1;
          4'd2:       if (b != RESP_BYTES) hdr_bad_d = 1'b1;
          4'd3, 4'd4: if (b != 8'h00)      sign_d    = 1'b1;
          4'd5, 4'd6, 4'd7, 4'd8: mag_d = {mag_q[23:0], b};
          4'd9:       crc_lo_d = b;
          default: begin
            // eleventh byte: verdict, header fault first
            push_o             = 1'b1;
            cnt_d              = FRAME_LEN;
            push_data_o.is_req = 1'b0;
            if (hdr_bad_q) begin
              push_data_o.status = STATUS_HDR;
            end else if (crc_q != rx_crc) begin
              push_data_o.status = STATUS_CRC;
            end else begin
              push_data_o.angle = sign_q ? (32'd0 - mag_q) : mag_q;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= ADDR_RESET;
      cnt_q     <= FRAME_LEN;
      crc_q     <= CRC_INIT;
      hdr_bad_q <= 1'b0;
      sign_q    <= 1'b0;
      mag_q     <= 32'd0;
      crc_lo_q  <= 8'h00;
    end else begin
      if (cfg_we_i) addr_q <= cfg_wdata_i;
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      hdr_bad_q <= hdr_bad_d;
      sign_q    <= sign_d;
      mag_q     <= mag_d;
      crc_lo_q  <= crc_lo_d;
    end
  end

endmodule

[src/mbaq_back.sv]
module mbaq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbaq_pkg::cmd_t    cmd_i,
  input  mbaq_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mbaq_pkg::out_t    out_data_o
);
  import mbaq_pkg::*;

  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        oval_q, oval_d;
  out_t        out_q, out_d;
  logic        slot_free;
  logic [7:0]  tx;

  assign slot_free   = !oval_q || out_ready_i;
  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (idx_q)
      3'd6:    tx = crc_q[7:0];
      3'd7:    tx = crc_q[15:8];
      default: tx = req_byte(idx_q);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    oval_d = oval_q;
    out_d  = out_q;
    pop_o  = 1'b0;
    if (slot_free) begin
      oval_d = 1'b0;
      if (busy_q) begin
        oval_d = 1'b1;
        out_d  = '{kind: KIND_TX, tx_byte: tx, last: (idx_q == 3'd7),
                   angle_tenths: 32'sd0, status: STATUS_OK};
        if (idx_q < 3'd6) crc_d = crc_feed(crc_q, tx);
        idx_d = idx_q + 3'd1;
        if (idx_q == 3'd7) busy_d = 1'b0;
      end else if (!q_stat_i.empty) begin
        pop_o  = 1'b1;
        oval_d = 1'b1;
        if (cmd_i.is_req) begin
          // address goes out now, rest of the frame follows from the counter
          out_d  = '{kind: KIND_TX, tx_byte: cmd_i.addr, last: 1'b0,
                     angle_tenths: 32'sd0, status: STATUS_OK};
          crc_d  = crc_feed(CRC_INIT, cmd_i.addr);
          idx_d  = 3'd1;
          busy_d = 1'b1;
        end else begin
          out_d  = '{kind: KIND_VERDICT, tx_byte: 8'h00, last: 1'b1,
                     angle_tenths: $signed(cmd_i.angle), status: cmd_i.status};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    out_q <= out_d;
  end

endmodule

[src/modbus_angle_query_frame_engine_top.sv]
// Channel   Handshake               Payload
// in        in_valid_i/in_ready_o   in_data_i   (operation, rx_byte)
// out       out_valid_o/out_ready_i out_data_o  (kind, tx_byte, last, angle_tenths, status)
// cfg       cfg_we_i                cfg_wdata_i (slave_address)
//
// A reply byte is taken every cycle; a verdict is pushed into the two-entry job queue on
// the eleventh byte and reaches out through the output register. A request occupies the
// output for its eight frame bytes: the back end emits one frame byte per cycle unless
// out stalls and folds each of the first six into the CRC with one bytewise CRC step.
// Input stalls only when the job queue is full; output stalls back up into it.
// Reset: address 1, reception idle, queue and output empty.
module modbus_angle_query_frame_engine_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mbaq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mbaq_pkg::out_t out_data_o
);
  import mbaq_pkg::*;

  logic    push, pop;
  cmd_t    push_data, pop_data;
  q_stat_t q_stat;

  mbaq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mbaq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  mbaq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_data),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
